### hw/rtl/bbafd_pkg.sv
// ---------------------------------------------------------------------------
// bbafd_pkg
// Types and constants shared by the boom/bucket angle frame decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package bbafd_pkg;

  // how the stored angle was obtained
  typedef enum logic [2:0] {
    KIND_FLOAT = 3'd0,
    KIND_LE    = 3'd1,
    KIND_BE    = 3'd2,
    KIND_ZERO  = 3'd3,
    KIND_ENC   = 3'd4
  } kind_t;

  // frame source
  typedef enum logic [1:0] {
    ACT_BODY   = 2'd0,
    ACT_BOOM   = 2'd1,
    ACT_BUCKET = 2'd2,
    ACT_STEER  = 2'd3
  } action_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BOOM_OFS   = 2'd0;
  localparam logic [1:0] CFG_BUCKET_OFS = 2'd1;
  localparam logic [1:0] CFG_STEER_OFS  = 2'd2;

  localparam logic [3:0]  FRAME_LEN     = 4'd8;
  // |f| <= 180.0 in float32 bits, sign removed
  localparam logic [30:0] FLOAT_MAX     = 31'h4334_0000;
  // below this exponent the rounded hundredths are always zero
  localparam logic [7:0]  EXP_MIN       = 8'd111;
  // shift minus one = 149 - exponent
  localparam logic [7:0]  SHIFT_BASE    = 8'd149;
  localparam logic [30:0] SCALE         = 31'd100;

  localparam logic signed [15:0] PITCH_LIMIT = 16'sd18000;
  localparam logic signed [18:0] REL_LIMIT   = 19'sd54000;
  localparam logic signed [18:0] STEER_LOW   = -19'sd18000;
  localparam logic signed [18:0] STEER_HIGH  = 19'sd83535;

endpackage

`default_nettype wire

### hw/rtl/boom_bucket_angle_frame_decoder.sv
// ---------------------------------------------------------------------------
// boom_bucket_angle_frame_decoder
// Decodes inclinometer and steering encoder frames into relative angles.
// ---------------------------------------------------------------------------
// pipeline: input register, decode, state update, result register; throughput:
//   one item per cycle while out_ready does not hold the result register
// frames with a length code other than 8 are dropped at the input register
// reset (synchronous, rst_n low): pipeline empty, pitches, encoder angle,
//   encoder flag and all offsets cleared to zero
`default_nettype none

module boom_bucket_angle_frame_decoder
  import bbafd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wdata,

  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_action,
  input  wire logic [3:0]          in_frame_length,
  input  wire logic [63:0]         in_payload,

  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [16:0]       out_arm_angle,
  output logic signed [16:0]       out_bucket_angle,
  output logic signed [17:0]       out_steer_angle,
  output logic signed [18:0]       out_steer_percent,
  output logic                     out_steer_valid,
  output logic [2:0]               out_decode_kind
);

  // configuration
  logic signed [15:0] boom_ofs_r, bucket_ofs_r, steer_ofs_r;

  // state
  logic signed [15:0] body_pitch_r, boom_pitch_r, bucket_pitch_r;
  logic [15:0]        enc_raw_r;
  logic               enc_seen_r;

  // stage 0: input register
  logic               s0_valid_r;
  action_t            s0_act_r;
  logic [63:0]        s0_payload_r;

  // stage 1: decoded frame
  logic               s1_valid_r;
  action_t            s1_act_r;
  kind_t              s1_kind_r;
  logic [30:0]        s1_prod_r;
  logic [5:0]         s1_sh_r;
  logic               s1_neg_r;
  logic               s1_fzero_r;
  logic signed [15:0] s1_alt_r;
  logic [15:0]        s1_enc_r;

  // stage 2: state updated, kind carried
  logic               s2_valid_r;
  kind_t              s2_kind_r;

  // result register
  logic               out_valid_r;
  kind_t              out_kind_r;
  logic signed [16:0] out_arm_r, out_bucket_r;
  logic signed [17:0] out_steer_r;
  logic               out_seen_r;

  logic s2_ready, s1_ready, s0_ready;
  logic s0_adv, s1_adv, s2_adv;

  assign s2_ready = !out_valid_r || out_ready;
  assign s2_adv   = s2_valid_r && s2_ready;
  assign s1_ready = !s2_valid_r || s2_ready;
  assign s1_adv   = s1_valid_r && s1_ready;
  assign s0_ready = !s1_valid_r || s1_ready;
  assign s0_adv   = s0_valid_r && s0_ready;
  assign in_ready = !s0_valid_r || s0_ready;

  // ---------------- stage 0 -> 1 decode ----------------
  logic [31:0]        fbits;
  logic [7:0]         fexp;
  logic [23:0]        fman;
  logic signed [15:0] le_val, be_val;
  logic               is_float, le_ok, be_ok;
  kind_t              kind_nxt;
  logic signed [15:0] alt_nxt;
  logic [7:0]         sh_full;

  always_comb begin
    fbits    = s0_payload_r[63:32];
    fexp     = fbits[30:23];
    fman     = {1'b1, fbits[22:0]};
    sh_full  = SHIFT_BASE - fexp;
    is_float = (fbits[30:0] <= FLOAT_MAX);
    le_val   = $signed({s0_payload_r[47:40], s0_payload_r[39:32]});
    be_val   = $signed({s0_payload_r[39:32], s0_payload_r[47:40]});
    le_ok    = (le_val >= -PITCH_LIMIT) && (le_val <= PITCH_LIMIT);
    be_ok    = (be_val >= -PITCH_LIMIT) && (be_val <= PITCH_LIMIT);
    if (s0_act_r == ACT_STEER) begin
      kind_nxt = KIND_ENC;
      alt_nxt  = '0;
    end else if (is_float) begin
      kind_nxt = KIND_FLOAT;
      alt_nxt  = '0;
    end else if (le_ok) begin
      kind_nxt = KIND_LE;
      alt_nxt  = le_val;
    end else if (be_ok) begin
      kind_nxt = KIND_BE;
      alt_nxt  = be_val;
    end else begin
      kind_nxt = KIND_ZERO;
      alt_nxt  = '0;
    end
  end

  // ---------------- stage 1 -> 2 rounding and state update ----------------
  logic [30:0]        shr;
  logic [30:0]        q_full;
  logic signed [15:0] q_mag, pitch_nxt;

  always_comb begin
    shr    = s1_prod_r >> s1_sh_r;
    // round half away from zero on the magnitude
    q_full = (shr + 31'd1) >> 1;
    q_mag  = $signed(q_full[15:0]);
    if (s1_kind_r == KIND_FLOAT) begin
      if (s1_fzero_r) begin
        pitch_nxt = '0;
      end else begin
        pitch_nxt = s1_neg_r ? -q_mag : q_mag;
      end
    end else begin
      pitch_nxt = s1_alt_r;
    end
  end

  // ---------------- stage 2 -> result ----------------
  logic signed [18:0] arm_sum, bucket_sum, steer_sum;
  logic signed [18:0] arm_clip, bucket_clip, steer_clip;

  always_comb begin
    arm_sum    = 19'(boom_pitch_r) - 19'(body_pitch_r) + 19'(boom_ofs_r);
    bucket_sum = 19'(bucket_pitch_r) - 19'(boom_pitch_r) + 19'(bucket_ofs_r);
    steer_sum  = $signed({3'b000, enc_raw_r}) + 19'(steer_ofs_r);
    if (arm_sum > REL_LIMIT) begin
      arm_clip = REL_LIMIT;
    end else if (arm_sum < -REL_LIMIT) begin
      arm_clip = -REL_LIMIT;
    end else begin
      arm_clip = arm_sum;
    end
    if (bucket_sum > REL_LIMIT) begin
      bucket_clip = REL_LIMIT;
    end else if (bucket_sum < -REL_LIMIT) begin
      bucket_clip = -REL_LIMIT;
    end else begin
      bucket_clip = bucket_sum;
    end
    if (!enc_seen_r) begin
      steer_clip = '0;
    end else if (steer_sum > STEER_HIGH) begin
      steer_clip = STEER_HIGH;
    end else if (steer_sum < STEER_LOW) begin
      steer_clip = STEER_LOW;
    end else begin
      steer_clip = steer_sum;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_valid && (in_frame_length == FRAME_LEN);
      end
      if (s0_ready) begin
        s1_valid_r <= s0_valid_r;
      end
      if (s1_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s2_ready) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // configuration and sensor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boom_ofs_r     <= '0;
      bucket_ofs_r   <= '0;
      steer_ofs_r    <= '0;
      body_pitch_r   <= '0;
      boom_pitch_r   <= '0;
      bucket_pitch_r <= '0;
      enc_raw_r      <= '0;
      enc_seen_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BOOM_OFS:   boom_ofs_r   <= cfg_wdata;
          CFG_BUCKET_OFS: bucket_ofs_r <= cfg_wdata;
          CFG_STEER_OFS:  steer_ofs_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (s1_adv) begin
        unique case (s1_act_r)
          ACT_BODY:   body_pitch_r   <= pitch_nxt;
          ACT_BOOM:   boom_pitch_r   <= pitch_nxt;
          ACT_BUCKET: bucket_pitch_r <= pitch_nxt;
          ACT_STEER: begin
            enc_raw_r  <= s1_enc_r;
            enc_seen_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s0_act_r     <= action_t'(in_action);
      s0_payload_r <= in_payload;
    end
    if (s0_ready) begin
      s1_act_r   <= s0_act_r;
      s1_kind_r  <= kind_nxt;
      s1_prod_r  <= {7'b0, fman} * SCALE;
      s1_sh_r    <= sh_full[5:0];
      s1_neg_r   <= fbits[31];
      s1_fzero_r <= (fexp < EXP_MIN);
      s1_alt_r   <= alt_nxt;
      s1_enc_r   <= {s0_payload_r[15:8], s0_payload_r[23:16]};
    end
    if (s1_ready) begin
      s2_kind_r <= s1_kind_r;
    end
    if (s2_adv) begin
      out_kind_r   <= s2_kind_r;
      out_arm_r    <= arm_clip[16:0];
      out_bucket_r <= bucket_clip[16:0];
      out_steer_r  <= steer_clip[17:0];
      out_seen_r   <= enc_seen_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_arm_angle     = out_arm_r;
  assign out_bucket_angle  = out_bucket_r;
  assign out_steer_angle   = out_steer_r;
  assign out_steer_percent = {out_steer_r, 1'b0};
  assign out_steer_valid   = out_seen_r;
  assign out_decode_kind   = out_kind_r;

endmodule

`default_nettype wire
